// ----- hdl/transducer_shadow_correction_top_macros.svh -----
// Assertion macros used by the shadow correction top level.
`ifndef TRANSDUCER_SHADOW_CORRECTION_TOP_MACROS_SVH
`define TRANSDUCER_SHADOW_CORRECTION_TOP_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define TSC_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define TSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hdl/tsc_pkg.sv -----
// Shared types, widths, latencies and tables of the shadow correction block.
package tsc_pkg;

    localparam int COMP_W       = 15;
    localparam int OUT_W        = 16;
    localparam int SQ_W         = 2 * COMP_W;
    localparam int RAD_W        = SQ_W + 32;
    localparam int ROOT_W       = 31;
    localparam int SQRT_STEPS   = 31;
    localparam int CORDIC_STEPS = 30;
    localparam int XY_W         = 34;
    localparam int Z_W          = 33;
    localparam int DIV_STEPS    = 16;
    localparam int SCALE_LAT    = DIV_STEPS + 4;
    localparam int LANE_LAT     = SQRT_STEPS + CORDIC_STEPS + SCALE_LAT;
    localparam int FRONT_LAT    = 3;
    localparam int TOTAL_LAT    = FRONT_LAT + LANE_LAT;
    localparam int NUM_LANES    = 3;

    localparam int FACTOR_W     = 16;
    localparam int ANGLE_W      = 15;
    localparam int CFG_DATA_W   = 16;

    localparam logic [FACTOR_W-1:0] FACTOR_LIMIT    = 16'd32768;
    localparam logic [ANGLE_W-1:0]  MAX_ANGLE_RESET = 15'd20016;
    localparam logic [FACTOR_W:0]   ONE_Q16         = 17'h10000;
    localparam logic [OUT_W-1:0]    SAT_POS         = 16'h7FFF;
    localparam logic [OUT_W-1:0]    SAT_NEG         = 16'h8000;

    // atan(2^-i) in Q0.30
    localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
        32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
        32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
        32'd32,        32'd16,        32'd8,         32'd4,         32'd2
    };

    typedef enum logic {
        CFG_SHADOW_FACTOR = 1'b0,
        CFG_MAX_ANGLE     = 1'b1
    } t_cfg_idx;

    // Sideband that travels with each component down its lane
    typedef struct packed {
        logic                     pass;
        logic signed [COMP_W-1:0] comp;
    } t_lane_tag;

endpackage

// ----- hdl/tsc_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module tsc_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [tsc_pkg::SQ_W-1:0]    i_rad,
    input  tsc_pkg::t_lane_tag          i_tag,
    output logic                        o_valid,
    output logic [tsc_pkg::ROOT_W-1:0]  o_root,
    output tsc_pkg::t_lane_tag          o_tag
);
    import tsc_pkg::*;

    logic             r_valid [SQRT_STEPS];
    logic [RAD_W-1:0] r_rem   [SQRT_STEPS];
    logic [RAD_W-1:0] r_root  [SQRT_STEPS];
    t_lane_tag        r_tag   [SQRT_STEPS];

    for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
        localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (SQRT_STEPS - 1 - s));

        logic             src_valid;
        logic [RAD_W-1:0] src_rem;
        logic [RAD_W-1:0] src_root;
        t_lane_tag        src_tag;
        logic [RAD_W:0]   trial;
        logic [RAD_W-1:0] n_rem;
        logic [RAD_W-1:0] n_root;

        if (s == 0) begin : g_head
            assign src_valid = i_valid;
            assign src_rem   = {i_rad, {(RAD_W - SQ_W){1'b0}}};
            assign src_root  = '0;
            assign src_tag   = i_tag;
        end else begin : g_body
            assign src_valid = r_valid[s-1];
            assign src_rem   = r_rem[s-1];
            assign src_root  = r_root[s-1];
            assign src_tag   = r_tag[s-1];
        end

        // try the next root bit against the remainder
        always_comb begin
            trial = {1'b0, src_root} + {1'b0, BIT};
            if ({1'b0, src_rem} >= trial) begin
                n_rem  = src_rem - trial[RAD_W-1:0];
                n_root = (src_root >> 1) + BIT;
            end else begin
                n_rem  = src_rem;
                n_root = src_root >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else begin
                r_valid[s] <= src_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= n_rem;
            r_root[s] <= n_root;
            r_tag[s]  <= src_tag;
        end
    end

    assign o_valid = r_valid[SQRT_STEPS-1];
    assign o_root  = r_root[SQRT_STEPS-1][ROOT_W-1:0];
    assign o_tag   = r_tag[SQRT_STEPS-1];

endmodule

// ----- hdl/tsc_cordic.sv -----
// Pipelined CORDIC vectoring, one rotation per stage, giving the angle in Q2.30.
module tsc_cordic (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [tsc_pkg::ROOT_W-1:0]    i_root,
    input  tsc_pkg::t_lane_tag            i_tag,
    output logic                          o_valid,
    output logic signed [tsc_pkg::Z_W-1:0] o_z,
    output tsc_pkg::t_lane_tag            o_tag
);
    import tsc_pkg::*;

    logic                    r_valid [CORDIC_STEPS];
    logic signed [XY_W-1:0]  r_x     [CORDIC_STEPS];
    logic signed [XY_W-1:0]  r_y     [CORDIC_STEPS];
    logic signed [Z_W-1:0]   r_z     [CORDIC_STEPS];
    t_lane_tag               r_tag   [CORDIC_STEPS];

    logic [COMP_W-1:0] mag;

    // magnitude of the component on the horizontal axis
    assign mag = i_tag.comp[COMP_W-1] ? (~i_tag.comp + 1'b1) : i_tag.comp;

    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
        localparam logic signed [Z_W-1:0] ANG = Z_W'(ATAN_Q30[s]);

        logic                   src_valid;
        logic signed [XY_W-1:0] src_x;
        logic signed [XY_W-1:0] src_y;
        logic signed [Z_W-1:0]  src_z;
        t_lane_tag              src_tag;
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        logic signed [XY_W-1:0] n_x;
        logic signed [XY_W-1:0] n_y;
        logic signed [Z_W-1:0]  n_z;

        if (s == 0) begin : g_head
            assign src_valid = i_valid;
            assign src_x     = {{(XY_W - COMP_W - 16){1'b0}}, mag, 16'b0};
            assign src_y     = {{(XY_W - ROOT_W){1'b0}}, i_root};
            assign src_z     = '0;
            assign src_tag   = i_tag;
        end else begin : g_body
            assign src_valid = r_valid[s-1];
            assign src_x     = r_x[s-1];
            assign src_y     = r_y[s-1];
            assign src_z     = r_z[s-1];
            assign src_tag   = r_tag[s-1];
        end

        // rotate toward the x axis
        always_comb begin
            dx = src_y >>> s;
            dy = src_x >>> s;
            if (src_y > 0) begin
                n_x = src_x + dx;
                n_y = src_y - dy;
                n_z = src_z + ANG;
            end else begin
                n_x = src_x - dx;
                n_y = src_y + dy;
                n_z = src_z - ANG;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else begin
                r_valid[s] <= src_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[s]   <= n_x;
            r_y[s]   <= n_y;
            r_z[s]   <= n_z;
            r_tag[s] <= src_tag;
        end
    end

    assign o_valid = r_valid[CORDIC_STEPS-1];
    assign o_z     = r_z[CORDIC_STEPS-1];
    assign o_tag   = r_tag[CORDIC_STEPS-1];

endmodule

// ----- hdl/tsc_scale.sv -----
// Angle rounding, divisor build, pipelined restoring divide and saturation.
module tsc_scale #(
    parameter int ANGLE_FRAC_BITS = 14
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic signed [tsc_pkg::Z_W-1:0]   i_z,
    input  tsc_pkg::t_lane_tag               i_tag,
    input  logic [tsc_pkg::FACTOR_W-1:0]     i_factor,
    input  logic [tsc_pkg::ANGLE_W-1:0]      i_max_angle,
    output logic                             o_valid,
    output logic signed [tsc_pkg::OUT_W-1:0] o_out
);
    import tsc_pkg::*;

    localparam int TH_W  = ANGLE_FRAC_BITS + 1;
    localparam int CW    = ANGLE_FRAC_BITS + 5;
    localparam int P1_W  = CW + 17;
    localparam int P2_W  = CW + 16;
    localparam int P3_W  = CW + COMP_W;
    localparam int DW    = CW + 18;
    localparam int DEN_W = DW + 1;
    localparam int RW    = CW + 34;

    // ---- stage A: round the angle, compare against the limit
    logic [Z_W-2:0]    zc;
    logic [Z_W-1:0]    zr;
    logic [TH_W-1:0]   theta;
    logic [CW-1:0]     t_val;
    logic [CW-1:0]     m_val;
    logic [COMP_W-1:0] mag;
    logic [FACTOR_W-1:0] fclamp;

    logic                r_a_valid;
    logic [CW-1:0]       r_a_t;
    logic [CW-1:0]       r_a_m;
    logic [COMP_W-1:0]   r_a_mag;
    logic [FACTOR_W-1:0] r_a_f;
    t_lane_tag           r_a_tag;

    always_comb begin
        zc     = i_z[Z_W-1] ? '0 : i_z[Z_W-2:0];
        zr     = {1'b0, zc} + (Z_W'(1) << (29 - ANGLE_FRAC_BITS));
        theta  = zr[(30 - ANGLE_FRAC_BITS) +: TH_W];
        t_val  = {theta, 4'b0};
        m_val  = CW'(i_max_angle) << (ANGLE_FRAC_BITS - 10);
        mag    = i_tag.comp[COMP_W-1] ? (~i_tag.comp + 1'b1) : i_tag.comp;
        fclamp = (i_factor > FACTOR_LIMIT) ? FACTOR_LIMIT : i_factor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_t        <= t_val;
        r_a_m        <= m_val;
        r_a_mag      <= mag;
        r_a_f        <= fclamp;
        r_a_tag.comp <= i_tag.comp;
        r_a_tag.pass <= i_tag.pass || (t_val > m_val) || (m_val == '0);
    end

    // ---- stage B: partial products
    logic [FACTOR_W:0] gain;
    logic [P1_W-1:0]   n_p1;
    logic [P2_W-1:0]   n_p2;
    logic [P3_W-1:0]   n_p3;

    logic              r_b_valid;
    logic [P1_W-1:0]   r_b_p1;
    logic [P2_W-1:0]   r_b_p2;
    logic [P3_W-1:0]   r_b_p3;
    t_lane_tag         r_b_tag;

    always_comb begin
        gain = ONE_Q16 - {1'b0, r_a_f};
        n_p1 = gain * r_a_m;
        n_p2 = r_a_f * r_a_t;
        n_p3 = r_a_mag * r_a_m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_p1  <= n_p1;
        r_b_p2  <= n_p2;
        r_b_p3  <= n_p3;
        r_b_tag <= r_a_tag;
    end

    // ---- stage C: rounded numerator and doubled divisor
    logic [DW-1:0] dsum;

    logic             r_c_valid;
    logic [RW-1:0]    r_c_num;
    logic [DEN_W-1:0] r_c_den;
    t_lane_tag        r_c_tag;

    assign dsum = DW'(r_b_p1) + DW'(r_b_p2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_num <= (RW'(r_b_p3) << 17) + RW'(dsum);
        r_c_den <= {dsum, 1'b0};
        r_c_tag <= r_b_tag;
    end

    // ---- restoring divide, one quotient bit per stage
    logic                 r_d_valid [DIV_STEPS];
    logic [RW-1:0]        r_d_rem   [DIV_STEPS];
    logic [DEN_W-1:0]     r_d_den   [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_d_q     [DIV_STEPS];
    t_lane_tag            r_d_tag   [DIV_STEPS];

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
        localparam int SH = DIV_STEPS - 1 - s;

        logic                 src_valid;
        logic [RW-1:0]        src_rem;
        logic [DEN_W-1:0]     src_den;
        logic [DIV_STEPS-1:0] src_q;
        t_lane_tag            src_tag;
        logic [RW-1:0]        sub;
        logic [RW-1:0]        n_rem;
        logic [DIV_STEPS-1:0] n_q;

        if (s == 0) begin : g_head
            assign src_valid = r_c_valid;
            assign src_rem   = r_c_num;
            assign src_den   = r_c_den;
            assign src_q     = '0;
            assign src_tag   = r_c_tag;
        end else begin : g_body
            assign src_valid = r_d_valid[s-1];
            assign src_rem   = r_d_rem[s-1];
            assign src_den   = r_d_den[s-1];
            assign src_q     = r_d_q[s-1];
            assign src_tag   = r_d_tag[s-1];
        end

        // subtract the shifted divisor where it fits
        always_comb begin
            sub = RW'(src_den) << SH;
            if (src_rem >= sub) begin
                n_rem = src_rem - sub;
                n_q   = src_q | (DIV_STEPS'(1) << SH);
            end else begin
                n_rem = src_rem;
                n_q   = src_q;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_valid[s] <= 1'b0;
            end else begin
                r_d_valid[s] <= src_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_d_rem[s] <= n_rem;
            r_d_den[s] <= src_den;
            r_d_q[s]   <= n_q;
            r_d_tag[s] <= src_tag;
        end
    end

    // ---- stage E: sign and saturate, or pass the component
    logic [DIV_STEPS-1:0] quo;
    t_lane_tag            e_tag;
    logic [OUT_W-1:0]     n_out;

    logic                 r_e_valid;
    logic [OUT_W-1:0]     r_e_out;

    assign quo   = r_d_q[DIV_STEPS-1];
    assign e_tag = r_d_tag[DIV_STEPS-1];

    always_comb begin
        if (e_tag.pass) begin
            n_out = {e_tag.comp[COMP_W-1], e_tag.comp};
        end else if (e_tag.comp[COMP_W-1]) begin
            n_out = (quo > SAT_NEG) ? SAT_NEG : (~quo + 1'b1);
        end else begin
            n_out = (quo > SAT_POS) ? SAT_POS : quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else begin
            r_e_valid <= r_d_valid[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_out <= n_out;
    end

    assign o_valid = r_e_valid;
    assign o_out   = r_e_out;

endmodule

// ----- hdl/transducer_shadow_correction_top.sv -----
// Top level of the sonic anemometer transducer shadow correction pipeline.
//
// Takes one wind vector per clock when start is high and busy is low, and
// returns the corrected vector marked by a one-cycle o_done pulse; there is
// no back-pressure, so the result must be taken in that cycle.
// The latency is set by the three component lanes, each built from a
// 31-stage square root, a 30-stage CORDIC angle unit and a 20-stage scaling
// and restoring divide section, after three front stages (capture, square,
// sum). busy is high only during reset. Configuration writes take effect at
// once and must be made while no vector is in flight.
`include "transducer_shadow_correction_top_macros.svh"

module transducer_shadow_correction_top #(
    parameter int ANGLE_FRAC_BITS = 14
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [tsc_pkg::COMP_W-1:0]    i_comp_x,
    input  logic signed [tsc_pkg::COMP_W-1:0]    i_comp_y,
    input  logic signed [tsc_pkg::COMP_W-1:0]    i_comp_z,
    input  logic [2:0]                           i_missing_in,
    input  logic                                 i_cfg_we,
    input  tsc_pkg::t_cfg_idx                    i_cfg_idx,
    input  logic [tsc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                 o_done,
    output logic signed [tsc_pkg::OUT_W-1:0]     o_out_x,
    output logic signed [tsc_pkg::OUT_W-1:0]     o_out_y,
    output logic signed [tsc_pkg::OUT_W-1:0]     o_out_z,
    output logic                                 o_all_missing
);
    import tsc_pkg::*;

    // configuration registers
    logic [FACTOR_W-1:0] r_shadow_factor;
    logic [ANGLE_W-1:0]  r_max_angle;
    logic                r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shadow_factor <= '0;
            r_max_angle     <= MAX_ANGLE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SHADOW_FACTOR: r_shadow_factor <= i_cfg_data;
                CFG_MAX_ANGLE:     r_max_angle     <= i_cfg_data[ANGLE_W-1:0];
                default:           r_max_angle     <= r_max_angle;
            endcase
        end
    end

    // hold busy through reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy = r_busy;

    // ---- front stage 1: capture the transfer
    logic                     accept;
    logic signed [COMP_W-1:0] comp_in [NUM_LANES];
    logic                     r1_valid;
    logic signed [COMP_W-1:0] r1_comp [NUM_LANES];
    logic                     r1_miss;

    assign accept     = start && !r_busy;
    assign comp_in[0] = i_comp_x;
    assign comp_in[1] = i_comp_y;
    assign comp_in[2] = i_comp_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_comp <= comp_in;
        r1_miss <= |i_missing_in;
    end

    // ---- front stage 2: squares
    logic                     r2_valid;
    logic [SQ_W-1:0]          r2_sq   [NUM_LANES];
    logic signed [COMP_W-1:0] r2_comp [NUM_LANES];
    logic                     r2_miss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_square
        logic signed [SQ_W-1:0] prod;

        assign prod = r1_comp[k] * r1_comp[k];

        always_ff @(posedge i_clk) begin
            r2_sq[k]   <= prod;
            r2_comp[k] <= r1_comp[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r2_miss <= r1_miss;
    end

    // ---- front stage 3: sum of squares and the bypass decision
    logic [SQ_W-1:0] total;
    logic            bypass;
    logic            r3_valid;
    logic [SQ_W-1:0] r3_rad [NUM_LANES];
    t_lane_tag       r3_tag [NUM_LANES];
    logic            r3_miss;

    assign total  = r2_sq[0] + r2_sq[1] + r2_sq[2];
    assign bypass = (r_shadow_factor == '0) || (total == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_sum
        always_ff @(posedge i_clk) begin
            r3_rad[k]      <= total - r2_sq[k];
            r3_tag[k].pass <= bypass;
            r3_tag[k].comp <= r2_comp[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r3_miss <= r2_miss;
    end

    // ---- component lanes
    logic                    lane_valid [NUM_LANES];
    logic signed [OUT_W-1:0] lane_out   [NUM_LANES];

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        logic                  sq_valid;
        logic [ROOT_W-1:0]     sq_root;
        t_lane_tag             sq_tag;
        logic                  cr_valid;
        logic signed [Z_W-1:0] cr_z;
        t_lane_tag             cr_tag;

        tsc_sqrt u_sqrt (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r3_valid),
            .i_rad   (r3_rad[k]),
            .i_tag   (r3_tag[k]),
            .o_valid (sq_valid),
            .o_root  (sq_root),
            .o_tag   (sq_tag)
        );

        tsc_cordic u_cordic (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_valid),
            .i_root  (sq_root),
            .i_tag   (sq_tag),
            .o_valid (cr_valid),
            .o_z     (cr_z),
            .o_tag   (cr_tag)
        );

        tsc_scale #(
            .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
        ) u_scale (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_valid     (cr_valid),
            .i_z         (cr_z),
            .i_tag       (cr_tag),
            .i_factor    (r_shadow_factor),
            .i_max_angle (r_max_angle),
            .o_valid     (lane_valid[k]),
            .o_out       (lane_out[k])
        );
    end

    // advance the missing flag alongside the lanes
    logic r_miss_line [LANE_LAT];

    always_ff @(posedge i_clk) begin
        r_miss_line[0] <= r3_miss;
        for (int i = 1; i < LANE_LAT; i++) begin
            r_miss_line[i] <= r_miss_line[i-1];
        end
    end

    // drive the result; a missing component zeroes all three
    assign o_done        = lane_valid[0];
    assign o_all_missing = r_miss_line[LANE_LAT-1];
    assign o_out_x       = r_miss_line[LANE_LAT-1] ? '0 : lane_out[0];
    assign o_out_y       = r_miss_line[LANE_LAT-1] ? '0 : lane_out[1];
    assign o_out_z       = r_miss_line[LANE_LAT-1] ? '0 : lane_out[2];

    `TSC_ASSERT_ALWAYS(a_lanes_aligned, i_clk, i_rst_n, (lane_valid[0] == lane_valid[1]) && (lane_valid[1] == lane_valid[2]), "component lanes out of step")
    `TSC_ASSERT_IMPLY(a_done_latency, i_clk, i_rst_n, o_done, $past(start && !busy, TOTAL_LAT), "result without a matching input transfer")
    `TSC_ASSERT_IMPLY(a_missing_zero, i_clk, i_rst_n, o_done && o_all_missing, (o_out_x == '0) && (o_out_y == '0) && (o_out_z == '0), "missing vector with nonzero output")

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the transducer shadow correction pipeline.
`timescale 1ns / 100ps

module tb;

    import tsc_pkg::*;

    localparam int FRAC        = 14;
    localparam int LIMIT_CYC   = 200000;
    localparam int RAND_ITEMS  = 400;

    typedef struct packed {
        logic signed [OUT_W-1:0] vx;
        logic signed [OUT_W-1:0] vy;
        logic signed [OUT_W-1:0] vz;
        logic                    miss;
    } t_wind_out;

    typedef struct packed {
        logic signed [COMP_W-1:0] cx;
        logic signed [COMP_W-1:0] cy;
        logic signed [COMP_W-1:0] cz;
        logic [2:0]               miss;
        logic                     has_exp;
        t_wind_out                exp_out;
    } t_vec_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic signed [COMP_W-1:0]  i_comp_x;
    logic signed [COMP_W-1:0]  i_comp_y;
    logic signed [COMP_W-1:0]  i_comp_z;
    logic [2:0]                i_missing_in;
    logic                      i_cfg_we;
    t_cfg_idx                  i_cfg_idx;
    logic [CFG_DATA_W-1:0]     i_cfg_data;
    logic                      o_done;
    logic signed [OUT_W-1:0]   o_out_x;
    logic signed [OUT_W-1:0]   o_out_y;
    logic signed [OUT_W-1:0]   o_out_z;
    logic                      o_all_missing;

    // local copy of the configuration
    logic [15:0] shadow_f;
    logic [14:0] max_ang;

    t_wind_out corrected_q[$];
    int        n_errors;
    int        cyc_count;

    transducer_shadow_correction_top dut (.*);

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // end the run if it hangs
    always @(posedge i_clk) begin
        cyc_count <= cyc_count + 1;
        if (cyc_count > LIMIT_CYC) begin
            $display("[transducer_shadow_correction_top] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_errors++;
    endtask

    function automatic longint unsigned isqrt64(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // angle between a component axis and the wind, Q2.14
    function automatic longint unsigned wind_angle(input int c, input longint unsigned oth);
        longint x, y, z, dx, dy;
        x = longint'(c < 0 ? -c : c) <<< 16;
        y = longint'(isqrt64(oth << 32));
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
            end
        end
        if (z < 0) z = 0;
        return (longint'(z) + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
    endfunction

    function automatic logic signed [OUT_W-1:0] shade_comp(input int c,
            input longint unsigned th, input longint unsigned f);
        longint unsigned t, m, mag, d, n, q;
        t = th << 4;
        m = longint'(max_ang) << (FRAC - 10);
        if (f == 0 || t > m || m == 0) return OUT_W'(c);
        d = (65536 - f) * m + f * t;
        mag = c < 0 ? -c : c;
        n = mag * 65536 * m;
        q = (2 * n + d) / (2 * d);
        if (c < 0) return q > 32768 ? SAT_NEG : OUT_W'(-longint'(q));
        return q > 32767 ? SAT_POS : OUT_W'(q);
    endfunction

    function automatic t_wind_out correct_wind(input t_vec_row r);
        t_wind_out       o;
        int              c[3];
        longint unsigned sq[3], tot, f;
        logic signed [OUT_W-1:0] res[3];
        c[0] = r.cx; c[1] = r.cy; c[2] = r.cz;
        f = shadow_f > FACTOR_LIMIT ? FACTOR_LIMIT : shadow_f;
        if (r.miss != 0) return '{vx: '0, vy: '0, vz: '0, miss: 1'b1};
        for (int k = 0; k < 3; k++) sq[k] = longint'(c[k]) * c[k];
        tot = sq[0] + sq[1] + sq[2];
        for (int k = 0; k < 3; k++) begin
            if (f == 0 || tot == 0) res[k] = OUT_W'(c[k]);
            else res[k] = shade_comp(c[k], wind_angle(c[k], tot - sq[k]), f);
        end
        o.vx = res[0]; o.vy = res[1]; o.vz = res[2]; o.miss = 1'b0;
        return o;
    endfunction

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_wind_out w;
        if (i_rst_n && o_done) begin
            if (corrected_q.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                w = corrected_q.pop_front();
                if (o_out_x !== w.vx) report_mismatch("out_x", int'(o_out_x), int'(w.vx));
                if (o_out_y !== w.vy) report_mismatch("out_y", int'(o_out_y), int'(w.vy));
                if (o_out_z !== w.vz) report_mismatch("out_z", int'(o_out_z), int'(w.vz));
                if (o_all_missing !== w.miss)
                    report_mismatch("all_missing", int'(o_all_missing), int'(w.miss));
            end
        end
    end

    // drop start and idle for a while, sometimes
    task automatic idle_gap();
        int n;
        if ($urandom_range(0, 2) != 0) return;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 3);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // transfer one vector and queue its expected result
    task automatic send_vec(input t_vec_row r, input bit gaps);
        t_wind_out p;
        if (gaps) idle_gap();
        start        <= 1'b1;
        i_comp_x     <= r.cx;
        i_comp_y     <= r.cy;
        i_comp_z     <= r.cz;
        i_missing_in <= r.miss;
        do @(posedge i_clk); while (busy);
        p = correct_wind(r);
        if (r.has_exp && p != r.exp_out) begin
            if (p.vx != r.exp_out.vx)
                report_mismatch("table row out_x", int'(p.vx), int'(r.exp_out.vx));
            if (p.vy != r.exp_out.vy)
                report_mismatch("table row out_y", int'(p.vy), int'(r.exp_out.vy));
            if (p.vz != r.exp_out.vz)
                report_mismatch("table row out_z", int'(p.vz), int'(r.exp_out.vz));
            if (p.miss != r.exp_out.miss)
                report_mismatch("table row all_missing", int'(p.miss),
                                int'(r.exp_out.miss));
        end
        corrected_q.insert(corrected_q.size(), r.has_exp ? r.exp_out : p);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (corrected_q.size() != 0) @(negedge i_clk);
        repeat (TOTAL_LAT + 10) @(negedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_SHADOW_FACTOR) shadow_f = val;
        else max_ang = val[14:0];
    endtask

    function automatic t_vec_row rand_vec();
        t_vec_row r;
        int sel;
        sel = $urandom_range(0, 9);
        r = '0;
        if (sel == 0) begin
            r.cx = COMP_W'($urandom); r.cy = COMP_W'($urandom); r.cz = COMP_W'($urandom);
        end else if (sel == 1) begin
            r.cx = COMP_W'(int'($urandom_range(0, 6)) - 3);
            r.cy = COMP_W'(int'($urandom_range(0, 6)) - 3);
            r.cz = COMP_W'(int'($urandom_range(0, 6)) - 3);
        end else begin
            r.cx = COMP_W'(int'($urandom_range(0, 19996)) - 9998);
            r.cy = COMP_W'(int'($urandom_range(0, 19996)) - 9998);
            r.cz = COMP_W'(int'($urandom_range(0, 19996)) - 9998);
        end
        r.miss = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
        return r;
    endfunction

    t_vec_row vec_table[$];

    initial begin
        logic [15:0] f_set[6];
        logic [14:0] a_set[6];
        n_errors     = 0;
        cyc_count    = 0;
        shadow_f     = '0;
        max_ang      = MAX_ANGLE_RESET;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_comp_x     = '0;
        i_comp_y     = '0;
        i_comp_z     = '0;
        i_missing_in = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_SHADOW_FACTOR;
        i_cfg_data   = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows at reset config (zero factor: inputs pass through)
        vec_table = '{
            '{cx: 15'sd9998, cy: -15'sd9998, cz: 15'sd0, miss: 3'd0, has_exp: 1'b1,
              exp_out: '{vx: 16'sd9998, vy: -16'sd9998, vz: 16'sd0, miss: 1'b0}},
            '{cx: 15'h4000, cy: 15'h3FFF, cz: 15'h7FFF, miss: 3'd0, has_exp: 1'b1,
              exp_out: '{vx: -16'sd16384, vy: 16'sd16383, vz: -16'sd1, miss: 1'b0}},
            '{cx: 15'sd5, cy: 15'sd6, cz: 15'sd7, miss: 3'd1, has_exp: 1'b1,
              exp_out: '{vx: '0, vy: '0, vz: '0, miss: 1'b1}},
            '{cx: 15'sd5, cy: 15'sd6, cz: 15'sd7, miss: 3'd4, has_exp: 1'b1,
              exp_out: '{vx: '0, vy: '0, vz: '0, miss: 1'b1}}
        };
        foreach (vec_table[i]) send_vec(vec_table[i], 1'b0);
        drain();

        // directed rows under correction, checked by the predictor
        write_cfg(CFG_SHADOW_FACTOR, 16'hFFFF);
        write_cfg(CFG_MAX_ANGLE, 16'd25736);
        vec_table = '{
            '{cx: 15'sd0, cy: 15'sd0, cz: 15'sd0, miss: 3'd0, has_exp: 1'b0,
              exp_out: '0},
            '{cx: 15'sd9998, cy: 15'sd0, cz: 15'sd0, miss: 3'd0, has_exp: 1'b0,
              exp_out: '0},
            '{cx: -15'sd9998, cy: -15'sd9998, cz: -15'sd9998, miss: 3'd0, has_exp: 1'b0,
              exp_out: '0},
            '{cx: 15'h4000, cy: 15'h4000, cz: 15'h3FFF, miss: 3'd0, has_exp: 1'b0,
              exp_out: '0},
            '{cx: 15'sd1, cy: 15'sd1, cz: 15'sd0, miss: 3'd0, has_exp: 1'b0,
              exp_out: '0},
            '{cx: 15'sd1, cy: 15'sd9998, cz: 15'sd0, miss: 3'd2, has_exp: 1'b0,
              exp_out: '0},
            '{cx: 15'sd1, cy: 15'sd9998, cz: 15'sd0, miss: 3'd0, has_exp: 1'b0,
              exp_out: '0}
        };
        foreach (vec_table[i]) send_vec(vec_table[i], 1'b0);
        drain();
        // zero maximum angle
        write_cfg(CFG_MAX_ANGLE, 16'd0);
        foreach (vec_table[i]) send_vec(vec_table[i], 1'b0);
        drain();

        // random phases over several settings
        f_set = '{16'd0, 16'd32768, 16'hFFFF, 16'd1, 16'd16384, 16'd40000};
        a_set = '{15'd20016, 15'd0, 15'd25736, 15'h7FFF, 15'd1, 15'd12000};
        for (int ph = 0; ph < 6; ph++) begin
            write_cfg(CFG_SHADOW_FACTOR, ph == 5 ? 16'($urandom) : f_set[ph]);
            write_cfg(CFG_MAX_ANGLE, {1'b0, a_set[ph]});
            for (int i = 0; i < RAND_ITEMS / 6; i++) begin
                send_vec(rand_vec(), 1'b1);
                // hold off until the pipeline is empty once per phase
                if (i == 20) begin
                    start <= 1'b0;
                    while (corrected_q.size() != 0) @(negedge i_clk);
                    @(negedge i_clk);
                end
            end
            drain();
        end

        if (n_errors == 0) begin
            $display("[transducer_shadow_correction_top] OK");
        end else begin
            $display("[transducer_shadow_correction_top] ERROR");
        end
        $finish;
    end

endmodule
